>>> hw/rtl/lhsl_pkg.sv
// Shared types, constants and helpers of the LED half-duplex serial link.
`timescale 1ns / 1ps

package lhsl_pkg;

  localparam int unsigned RING_DEPTH_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [9:0]  BIT_THRESHOLD_RST = 10'd290;
  localparam logic [15:0] PHASE_PERIOD_RST  = 16'd16;
  localparam logic [7:0]  SYNC_LENGTH_RST   = 8'd8;
  localparam logic [3:0]  DATA_BITS_RST     = 4'd8;
  localparam logic        STOP_ENABLE_RST   = 1'b1;
  localparam logic        STOP_LEVEL_RST    = 1'b0;
  localparam logic [7:0]  LFSR_SEED         = 8'h01;
  localparam logic [7:0]  LFSR_TAPS         = 8'hB8;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_LOAD = 2'd1,
    FUNC_POP  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_THRESHOLD = 3'd0,
    CFG_PHASE_PERIOD  = 3'd1,
    CFG_SYNC_LENGTH   = 3'd2,
    CFG_DATA_BITS     = 3'd3,
    CFG_STOP_ENABLE   = 3'd4,
    CFG_STOP_LEVEL    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] func;
    logic [9:0] adc_sample;
    logic [7:0] tx_byte_in;
  } in_t;

  typedef struct packed {
    logic       pin_drive;
    logic       led_on;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       tx_taken;
    logic       rx_ready;
    logic       tx_ready;
    logic [1:0] link_state;
  } out_t;

  typedef struct packed {
    logic [9:0]  bit_threshold;
    logic [15:0] phase_period;
    logic [7:0]  sync_length;
    logic [3:0]  data_bits;
    logic        stop_enable;
    logic        stop_level;
  } cfg_t;

  // Residue mod 3 of a byte: base-4 digits sum to the same residue.
  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [3:0] s;
    logic [1:0] r;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
      default:                       r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/lhsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lhsl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lhsl_link.sv
// Link state machine: tick phases, sync search, deframing, framing and ring bookkeeping.
`timescale 1ns / 1ps

module lhsl_link #(
  parameter int unsigned RING_DEPTH = lhsl_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  lhsl_pkg::in_t                 item_i,
  input  lhsl_pkg::cfg_t                cfg_i,
  output lhsl_pkg::out_t                res_o,
  output logic                          ram_we_o,
  output logic [$clog2(RING_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]                    ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(RING_DEPTH)-1:0] ram_raddr_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_SEARCH  = 2'd0,
    MODE_SYNCING = 2'd1,
    MODE_SYNCED  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PH_SAMPLE  = 2'd0,
    PH_DRIVE   = 2'd1,
    PH_RELEASE = 2'd2
  } phase_e;

  mode_e        mode_q, mode_d;
  phase_e       phase_q, phase_d;
  logic [15:0]  wait_q, wait_d;
  logic [7:0]   sync_q, sync_d;
  logic         recv_q, recv_d;
  logic         xmit_q, xmit_d;
  logic [3:0]   rx_pos_q, rx_pos_d;
  logic [3:0]   tx_pos_q, tx_pos_d;
  logic [7:0]   tx_shift_q, tx_shift_d;
  logic [7:0]   rx_shift_q, rx_shift_d;
  logic [AW-1:0] wpos_q, wpos_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [7:0]   lfsr_q, lfsr_d;
  logic         pin_q, pin_d;
  logic         led_q, led_d;

  logic         one;
  logic [3:0]   tx_end;
  logic [3:0]   tx_idx;
  logic         synced;
  logic         ring_full;
  logic         ram_we, ram_re, taken;
  logic [7:0]   wr_byte;
  logic [FW:0]  w_ext, f_ext, rd_full;

  assign one       = (~item_i.adc_sample) > cfg_i.bit_threshold;
  assign tx_end    = cfg_i.data_bits + 4'd1;
  assign tx_idx    = tx_pos_q - 4'd1;
  assign synced    = (mode_q == MODE_SYNCED);
  assign ring_full = (fill_q >= FW'(RING_DEPTH));

  // Oldest stored byte sits fill entries behind the write position.
  assign w_ext   = (FW + 1)'(wpos_q);
  assign f_ext   = (FW + 1)'(fill_q);
  assign rd_full = (w_ext >= f_ext) ? (w_ext - f_ext)
                                    : (w_ext + (FW + 1)'(RING_DEPTH) - f_ext);

  always_comb begin
    mode_d     = mode_q;
    phase_d    = phase_q;
    wait_d     = wait_q;
    sync_d     = sync_q;
    recv_d     = recv_q;
    xmit_d     = xmit_q;
    rx_pos_d   = rx_pos_q;
    tx_pos_d   = tx_pos_q;
    tx_shift_d = tx_shift_q;
    rx_shift_d = rx_shift_q;
    wpos_d     = wpos_q;
    fill_d     = fill_q;
    lfsr_d     = lfsr_q;
    pin_d      = pin_q;
    led_d      = led_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    taken      = 1'b0;
    wr_byte    = rx_shift_q;

    case (lhsl_pkg::func_e'(item_i.func))
      lhsl_pkg::FUNC_TICK: begin
        if (wait_q != 16'd0) begin
          wait_d = wait_q - 16'd1;
        end else if (phase_q == PH_DRIVE) begin
          led_d = 1'b0;
          if (mode_q == MODE_SEARCH) begin
            led_d = 1'b1;
          end else if (mode_q == MODE_SYNCING) begin
            led_d = (sync_q < cfg_i.sync_length);
          end else if (xmit_q) begin
            if (tx_pos_q == 4'd0) begin
              led_d    = 1'b1;
              tx_pos_d = 4'd1;
            end else if (tx_pos_q == tx_end) begin
              led_d  = cfg_i.stop_level;
              xmit_d = 1'b0;
            end else begin
              led_d    = !tx_idx[3] && tx_shift_q[tx_idx[2:0]];
              tx_pos_d = tx_pos_q + 4'd1;
              if (!cfg_i.stop_enable && tx_pos_d == tx_end) begin
                xmit_d = 1'b0;
              end
            end
          end
          pin_d   = 1'b1;
          phase_d = PH_RELEASE;
          wait_d  = cfg_i.phase_period;
        end else if (phase_q == PH_RELEASE) begin
          pin_d   = 1'b0;
          led_d   = 1'b0;
          phase_d = PH_SAMPLE;
          wait_d  = cfg_i.phase_period >> 1;
        end else begin
          wait_d  = cfg_i.phase_period >> 1;
          phase_d = PH_DRIVE;
          case (mode_q)
            MODE_SEARCH: begin
              if (one) begin
                sync_d = sync_q + 8'd1;
                if (sync_d >= cfg_i.sync_length) begin
                  mode_d = MODE_SYNCING;
                  sync_d = 8'd0;
                end
              end else begin
                // Drop the count and nudge the sample point by a random 0..2 ticks.
                sync_d = 8'd0;
                lfsr_d = (lfsr_q >> 1) ^ (lfsr_q[0] ? lhsl_pkg::LFSR_TAPS : 8'h00);
                wait_d = wait_d + 16'(lhsl_pkg::mod3(lfsr_d));
              end
            end
            MODE_SYNCING: begin
              if (sync_q < cfg_i.sync_length) begin
                sync_d = sync_q + 8'd1;
              end
              if (!one) begin
                mode_d   = MODE_SYNCED;
                fill_d   = '0;
                rx_pos_d = 4'd0;
                recv_d   = 1'b0;
                xmit_d   = 1'b0;
                sync_d   = cfg_i.sync_length;
              end
            end
            default: begin
              if (sync_q != 8'd0) begin
                sync_d = sync_q - 8'd1;
              end
              if (recv_q) begin
                if (cfg_i.stop_enable && rx_pos_q == cfg_i.data_bits) begin
                  if (one != cfg_i.stop_level) begin
                    mode_d = MODE_SEARCH;
                    sync_d = 8'd0;
                  end else begin
                    ram_we = 1'b1;
                  end
                end else begin
                  if (one && !rx_pos_q[3]) begin
                    rx_shift_d[rx_pos_q[2:0]] = 1'b1;
                  end
                  rx_pos_d = rx_pos_q + 4'd1;
                  wr_byte  = rx_shift_d;
                  if (!cfg_i.stop_enable && rx_pos_d == cfg_i.data_bits) begin
                    ram_we = 1'b1;
                  end
                end
                if (ram_we) begin
                  wpos_d = (wpos_q == AW'(RING_DEPTH - 1)) ? '0 : wpos_q + AW'(1);
                  fill_d = fill_q + FW'(1);
                  recv_d = 1'b0;
                end
              end else if (one) begin
                if (ring_full) begin
                  mode_d = MODE_SEARCH;
                  sync_d = 8'd0;
                end else begin
                  rx_shift_d = 8'd0;
                  rx_pos_d   = 4'd0;
                  recv_d     = 1'b1;
                end
              end
            end
          endcase
        end
      end
      lhsl_pkg::FUNC_LOAD: begin
        if (synced && sync_q == 8'd0 && !xmit_q) begin
          tx_shift_d = item_i.tx_byte_in;
          tx_pos_d   = 4'd0;
          xmit_d     = 1'b1;
          taken      = 1'b1;
        end
      end
      lhsl_pkg::FUNC_POP: begin
        if (synced && fill_q != '0) begin
          ram_re = 1'b1;
          fill_d = fill_q - FW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_SEARCH;
      phase_q    <= PH_SAMPLE;
      wait_q     <= '0;
      sync_q     <= '0;
      recv_q     <= 1'b0;
      xmit_q     <= 1'b0;
      rx_pos_q   <= '0;
      tx_pos_q   <= '0;
      tx_shift_q <= '0;
      rx_shift_q <= '0;
      wpos_q     <= '0;
      fill_q     <= '0;
      lfsr_q     <= lhsl_pkg::LFSR_SEED;
      pin_q      <= 1'b0;
      led_q      <= 1'b0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      wait_q     <= wait_d;
      sync_q     <= sync_d;
      recv_q     <= recv_d;
      xmit_q     <= xmit_d;
      rx_pos_q   <= rx_pos_d;
      tx_pos_q   <= tx_pos_d;
      tx_shift_q <= tx_shift_d;
      rx_shift_q <= rx_shift_d;
      wpos_q     <= wpos_d;
      fill_q     <= fill_d;
      lfsr_q     <= lfsr_d;
      pin_q      <= pin_d;
      led_q      <= led_d;
    end
  end

  always_comb begin
    res_o            = '0;
    res_o.pin_drive  = pin_d;
    res_o.led_on     = led_d;
    res_o.rx_valid   = ram_re;
    res_o.tx_taken   = taken;
    res_o.rx_ready   = (mode_d == MODE_SYNCED) && (fill_d != '0);
    res_o.tx_ready   = (mode_d == MODE_SYNCED) && (sync_d == 8'd0) && !xmit_d;
    res_o.link_state = mode_d;
  end

  assign ram_we_o    = step_i && ram_we;
  assign ram_waddr_o = wpos_q;
  assign ram_wdata_o = wr_byte;
  assign ram_re_o    = step_i && ram_re;
  assign ram_raddr_o = rd_full[AW-1:0];

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(RING_DEPTH))
    else $error("ring fill count beyond ring depth");

  a_dark_when_released : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pin_q |-> !led_q)
    else $error("LED lit while pin released");

  a_write_when_synced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (synced && recv_q && !ring_full))
    else $error("ring write outside a received character");

  a_pop_needs_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |=> fill_q == $past(fill_q) - FW'(1))
    else $error("pop did not consume a ring entry");

endmodule

>>> hw/rtl/led_half_duplex_serial_link_unit.sv
// Top level of the LED half-duplex serial link: config registers, handshakes, result register.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one beat per
//   request: func 0 is a time tick, 1 loads a transmit byte, 2 pops a received
//   byte, 3 does nothing. Output channel (out_valid_o / out_stall_i /
//   out_data_o) returns exactly one result beat per input beat, in order,
//   showing pin drive, LED level, popped byte and link status after the step.
//   Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i);
//   write it only while no beat is in flight. Unknown indexes are ignored.
//   Latency: the result of a beat is presented on the cycle after it is
//   accepted. Throughput: one beat per cycle unless stalled; the link state and
//   the ring bookkeeping update in one pass per beat, and a popped byte comes
//   straight from the ring RAM's registered read port into the result.
//   Stall: while a result waits with out_stall_i high, in_stall_o is raised
//   and the result, including the popped byte, holds. A new beat is taken in
//   the same cycle the waiting result leaves.
//   Reset: the link searches for a preamble, the pin is released, the ring is
//   empty and the config registers return to their defaults. The ring RAM
//   itself is not cleared; only written entries are ever popped.

module led_half_duplex_serial_link_unit #(
  parameter int unsigned RING_DEPTH = lhsl_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lhsl_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lhsl_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [lhsl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lhsl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);

  lhsl_pkg::cfg_t cfg_q;
  lhsl_pkg::out_t res;
  lhsl_pkg::out_t res_q;
  logic           out_valid_q;
  logic           step;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  // Hold off input only while a result is parked and the receiver stalls.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  // Register writes; mask each value to its field width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_threshold <= lhsl_pkg::BIT_THRESHOLD_RST;
      cfg_q.phase_period  <= lhsl_pkg::PHASE_PERIOD_RST;
      cfg_q.sync_length   <= lhsl_pkg::SYNC_LENGTH_RST;
      cfg_q.data_bits     <= lhsl_pkg::DATA_BITS_RST;
      cfg_q.stop_enable   <= lhsl_pkg::STOP_ENABLE_RST;
      cfg_q.stop_level    <= lhsl_pkg::STOP_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (lhsl_pkg::cfg_idx_e'(cfg_index_i))
        lhsl_pkg::CFG_BIT_THRESHOLD: cfg_q.bit_threshold <= cfg_wdata_i[9:0];
        lhsl_pkg::CFG_PHASE_PERIOD:  cfg_q.phase_period  <= cfg_wdata_i[15:0];
        lhsl_pkg::CFG_SYNC_LENGTH:   cfg_q.sync_length   <= cfg_wdata_i[7:0];
        lhsl_pkg::CFG_DATA_BITS:     cfg_q.data_bits     <= cfg_wdata_i[3:0];
        lhsl_pkg::CFG_STOP_ENABLE:   cfg_q.stop_enable   <= cfg_wdata_i[0];
        lhsl_pkg::CFG_STOP_LEVEL:    cfg_q.stop_level    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  lhsl_link #(
    .RING_DEPTH (RING_DEPTH)
  ) u_link (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_data_i),
    .cfg_i       (cfg_q),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  // Receive ring; the read port only moves on a pop, so its data holds under stall.
  lhsl_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register: load on every accepted beat, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  always_comb begin
    out_data_o         = res_q;
    out_data_o.rx_byte = res_q.rx_valid ? ram_rdata : 8'd0;
  end

  assign out_valid_o = out_valid_q;

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result parked");

  a_result_follows_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("accepted beat produced no result");

  a_pop_result_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> out_data_o.rx_valid)
    else $error("ring read without a popped result");

endmodule

>>> bench/led_half_duplex_serial_link_unit_test.sv
// Self-checking testbench of the LED half-duplex serial link: directed and random beats.
`timescale 1ns / 1ps

module led_half_duplex_serial_link_unit_test;

  localparam int          RING        = lhsl_pkg::RING_DEPTH_DEF;
  localparam int          HOLD_CYCLES = 48;
  localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI  = 3'd7;

  typedef enum logic [1:0] {
    LINK_SEARCH  = 2'd0,
    LINK_SYNCING = 2'd1,
    LINK_SYNCED  = 2'd2
  } link_e;

  typedef enum logic [1:0] {
    SLOT_SAMPLE  = 2'd0,
    SLOT_DRIVE   = 2'd1,
    SLOT_RELEASE = 2'd2
  } slot_e;

  // Mirror of the link: tracks mode, timing, ring and transmitter per accepted beat
  // and queues the status word that each beat must produce.
  class link_mirror;
    logic [9:0]  thr;
    logic [15:0] period;
    logic [7:0]  sync_len;
    logic [3:0]  n_bits;
    logic        stop_en;
    logic        stop_lvl;
    link_e       mode;
    slot_e       cur_slot;
    logic [15:0] wait_cnt;
    logic [7:0]  sync_cnt;
    logic        receiving;
    logic        sending;
    logic [3:0]  rx_pos;
    logic [3:0]  tx_pos;
    logic [7:0]  tx_shift;
    logic [7:0]  ring [RING];
    logic [3:0]  wr_pos;
    logic [4:0]  fill;
    logic [7:0]  lfsr;
    logic        pin;
    logic        led;
    lhsl_pkg::out_t expected_status[$];
    int          errors;

    function new();
      thr = lhsl_pkg::BIT_THRESHOLD_RST;
      period = lhsl_pkg::PHASE_PERIOD_RST;
      sync_len = lhsl_pkg::SYNC_LENGTH_RST;
      n_bits = lhsl_pkg::DATA_BITS_RST;
      stop_en = lhsl_pkg::STOP_ENABLE_RST;
      stop_lvl = lhsl_pkg::STOP_LEVEL_RST;
      mode = LINK_SEARCH;
      cur_slot = SLOT_SAMPLE;
      wait_cnt = '0;
      sync_cnt = '0;
      receiving = 1'b0;
      sending = 1'b0;
      rx_pos = '0;
      tx_pos = '0;
      tx_shift = '0;
      foreach (ring[k]) ring[k] = '0;
      wr_pos = '0;
      fill = '0;
      lfsr = lhsl_pkg::LFSR_SEED;
      pin = 1'b0;
      led = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [lhsl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
        lhsl_pkg::CFG_BIT_THRESHOLD: thr = v[9:0];
        lhsl_pkg::CFG_PHASE_PERIOD:  period = v;
        lhsl_pkg::CFG_SYNC_LENGTH:   sync_len = v[7:0];
        lhsl_pkg::CFG_DATA_BITS:     n_bits = v[3:0];
        lhsl_pkg::CFG_STOP_ENABLE:   stop_en = v[0];
        lhsl_pkg::CFG_STOP_LEVEL:    stop_lvl = v[0];
        default: ;
      endcase
    endfunction

    function logic [1:0] draw_jitter();
      logic lsb;
      lsb = lfsr[0];
      lfsr = lfsr >> 1;
      if (lsb) lfsr = lfsr ^ lhsl_pkg::LFSR_TAPS;
      return 2'(lfsr % 8'd3);
    endfunction

    function void drop_sync();
      mode = LINK_SEARCH;
      sync_cnt = '0;
    endfunction

    function void close_char();
      wr_pos = wr_pos + 4'd1;
      fill = fill + 5'd1;
      receiving = 1'b0;
    endfunction

    function void take_sample(logic [9:0] adc);
      logic [9:0] inv;
      logic       one;
      inv = 10'd1023 - adc;
      one = inv > thr;
      wait_cnt = period >> 1;
      case (mode)
        LINK_SEARCH: begin
          if (one) begin
            sync_cnt = sync_cnt + 8'd1;
            if (sync_cnt >= sync_len) begin
              mode = LINK_SYNCING;
              sync_cnt = '0;
            end
          end else begin
            sync_cnt = '0;
            wait_cnt = wait_cnt + 16'(draw_jitter());
          end
        end
        LINK_SYNCING: begin
          if (sync_cnt < sync_len) sync_cnt = sync_cnt + 8'd1;
          if (!one) begin
            mode = LINK_SYNCED;
            fill = '0;
            rx_pos = '0;
            receiving = 1'b0;
            sending = 1'b0;
            sync_cnt = sync_len;
          end
        end
        default: begin
          if (sync_cnt != 0) sync_cnt = sync_cnt - 8'd1;
          if (receiving) begin
            if (stop_en && rx_pos == n_bits) begin
              if (one != stop_lvl) drop_sync();
              else close_char();
            end else begin
              if (one && rx_pos < 4'd8) ring[wr_pos][rx_pos[2:0]] = 1'b1;
              rx_pos = rx_pos + 4'd1;
              if (!stop_en && rx_pos == n_bits) close_char();
            end
          end else if (one) begin
            if (fill >= RING) drop_sync();
            else begin
              ring[wr_pos] = '0;
              rx_pos = '0;
              receiving = 1'b1;
            end
          end
        end
      endcase
      cur_slot = SLOT_DRIVE;
    endfunction

    function void drive_pin();
      logic       lvl;
      logic [3:0] last;
      logic [3:0] idx;
      lvl = 1'b0;
      last = n_bits + 4'd1;
      if (mode == LINK_SEARCH) lvl = 1'b1;
      else if (mode == LINK_SYNCING) lvl = sync_cnt < sync_len;
      else if (sending) begin
        if (tx_pos == 4'd0) begin
          lvl = 1'b1;
          tx_pos = 4'd1;
        end else if (tx_pos == last) begin
          lvl = stop_lvl;
          sending = 1'b0;
        end else begin
          idx = tx_pos - 4'd1;
          lvl = idx < 4'd8 && tx_shift[idx[2:0]];
          tx_pos = tx_pos + 4'd1;
          if (!stop_en && tx_pos == last) sending = 1'b0;
        end
      end
      pin = 1'b1;
      led = lvl;
      cur_slot = SLOT_RELEASE;
      wait_cnt = period;
    endfunction

    function void note_request(lhsl_pkg::in_t r);
      lhsl_pkg::out_t o;
      logic           synced;
      logic [3:0]     head;
      synced = mode == LINK_SYNCED;
      o = '0;
      case (lhsl_pkg::func_e'(r.func))
        lhsl_pkg::FUNC_TICK: begin
          if (wait_cnt != 0) wait_cnt = wait_cnt - 16'd1;
          else if (cur_slot == SLOT_DRIVE) drive_pin();
          else if (cur_slot == SLOT_RELEASE) begin
            pin = 1'b0;
            led = 1'b0;
            cur_slot = SLOT_SAMPLE;
            wait_cnt = period >> 1;
          end else take_sample(r.adc_sample);
        end
        lhsl_pkg::FUNC_LOAD: begin
          if (synced && sync_cnt == 0 && !sending) begin
            tx_shift = r.tx_byte_in;
            tx_pos = '0;
            sending = 1'b1;
            o.tx_taken = 1'b1;
          end
        end
        lhsl_pkg::FUNC_POP: begin
          if (synced && fill != 0) begin
            head = wr_pos - fill[3:0];
            o.rx_byte = ring[head];
            o.rx_valid = 1'b1;
            fill = fill - 5'd1;
          end
        end
        default: ;
      endcase
      o.pin_drive = pin;
      o.led_on = led;
      o.rx_ready = mode == LINK_SYNCED && fill != 0;
      o.tx_ready = mode == LINK_SYNCED && sync_cnt == 0 && !sending;
      o.link_state = mode;
      expected_status.push_back(o);
    endfunction

    function void same(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_status(lhsl_pkg::out_t got);
      lhsl_pkg::out_t want;
      if (expected_status.size() == 0) begin
        errors++;
        $error("status beat with no request outstanding: %0h", got);
        return;
      end
      want = expected_status.pop_front();
      same("pin_drive", want.pin_drive, got.pin_drive);
      same("led_on", want.led_on, got.led_on);
      same("rx_byte", want.rx_byte, got.rx_byte);
      same("rx_valid", want.rx_valid, got.rx_valid);
      same("tx_taken", want.tx_taken, got.tx_taken);
      same("rx_ready", want.rx_ready, got.rx_ready);
      same("tx_ready", want.tx_ready, got.tx_ready);
      same("link_state", want.link_state, got.link_state);
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  lhsl_pkg::in_t                   in_data_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  lhsl_pkg::out_t                  out_data_o;
  logic                            cfg_we_i = 1'b0;
  logic [lhsl_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [lhsl_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  link_mirror board = new();

  // Bits the far end puts on the pin, one per sample slot.
  logic line_bits[$];
  bit   send_gaps_on = 1'b1;
  bit   stall_gaps_on = 1'b1;
  bit   hold_off_req = 1'b0;

  led_half_duplex_serial_link_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check every status beat the moment it leaves; values are read before the edge updates them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_status(out_data_o);
  end

  // Receiver side: random stall bursts, plus one long hold-off on request so that the
  // result register stays full and the block has to stall its input.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (stall_gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL led_half_duplex_serial_link_unit");
    $finish;
  end

  function automatic lhsl_pkg::in_t req(lhsl_pkg::func_e f, logic [9:0] adc,
                                        logic [7:0] data);
    lhsl_pkg::in_t r;
    r.func = f;
    r.adc_sample = adc;
    r.tx_byte_in = data;
    return r;
  endfunction

  // Pick a reading that decodes to the wanted bit, now and then right at the threshold.
  function automatic logic [9:0] level_to_adc(logic one);
    int lim;
    lim = 1023 - int'(board.thr);
    if (one && lim > 0)
      return 10'(($urandom_range(0, 7) == 0) ? lim - 1 : $urandom_range(0, lim - 1));
    if (!one)
      return 10'(($urandom_range(0, 7) == 0) ? lim : $urandom_range(lim, 1023));
    return 10'($urandom_range(0, 1023));
  endfunction

  // Refill the far end's bit stream from what the link is doing now: a preamble while
  // searching, the closing zero while syncing, framed characters once synchronized.
  // A few sequences are noise or carry a bad stop bit.
  function automatic void plan_line_bits();
    case (board.mode)
      LINK_SEARCH: begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 4)) line_bits.push_back(1'($urandom));
        end else begin
          repeat (int'(board.sync_len) + $urandom_range(0, 2)) line_bits.push_back(1'b1);
          line_bits.push_back(1'b0);
        end
      end
      LINK_SYNCING: begin
        repeat ($urandom_range(0, 1)) line_bits.push_back(1'b1);
        line_bits.push_back(1'b0);
      end
      default: begin
        line_bits.push_back(1'b1);
        repeat (int'(board.n_bits)) line_bits.push_back(1'($urandom));
        if (board.stop_en)
          line_bits.push_back(($urandom_range(0, 11) == 0) ? !board.stop_lvl : board.stop_lvl);
        repeat ($urandom_range(0, 2)) line_bits.push_back(1'b0);
        if ($urandom_range(0, 15) == 0)
          repeat ($urandom_range(1, 3)) line_bits.push_back(1'($urandom));
      end
    endcase
  endfunction

  function automatic lhsl_pkg::in_t make_request(int pop_pct);
    lhsl_pkg::in_t r;
    int            pick;
    bit            can_load;
    bit            can_pop;
    r.func = lhsl_pkg::FUNC_TICK;
    r.adc_sample = 10'($urandom_range(0, 1023));
    r.tx_byte_in = 8'($urandom);
    pick = $urandom_range(0, 99);
    can_load = board.mode == LINK_SYNCED && board.sync_cnt == 0 && !board.sending;
    can_pop = board.mode == LINK_SYNCED && board.fill != 0;
    if (can_load && pick < 25) r.func = lhsl_pkg::FUNC_LOAD;
    else if (can_pop && pick >= 100 - pop_pct) r.func = lhsl_pkg::FUNC_POP;
    else if (pick < 2) r.func = lhsl_pkg::FUNC_NOP;
    else if (pick < 4 && !can_load) r.func = lhsl_pkg::FUNC_LOAD;
    else if (pick < 6 && !can_pop) r.func = lhsl_pkg::FUNC_POP;
    else if (board.wait_cnt == 0 && board.cur_slot == SLOT_SAMPLE) begin
      if (line_bits.size() == 0) plan_line_bits();
      r.adc_sample = level_to_adc(line_bits.pop_front());
    end
    return r;
  endfunction

  // Offer one beat, optionally after an idle burst, and note it once it is taken.
  task automatic send_item(lhsl_pkg::in_t item);
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    board.note_request(item);
  endtask

  // Drop valid and hold until every status beat is back, then let the pipe settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.expected_status.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lhsl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.set_reg(idx, v);
  endtask

  // Set bits above the register's width half of the time; the block must mask them.
  function automatic logic [15:0] pad(logic [15:0] v, int w);
    logic [15:0] junk;
    junk = 16'($urandom) & ~((16'd1 << w) - 16'd1);
    return ($urandom_range(0, 1) == 0) ? v : (v | junk);
  endfunction

  task automatic program_link(logic [9:0] thr, logic [15:0] period, logic [7:0] sync_len,
                              logic [3:0] n_bits, logic stop_en, logic stop_lvl);
    write_reg(lhsl_pkg::CFG_BIT_THRESHOLD, pad(16'(thr), 10));
    write_reg(lhsl_pkg::CFG_PHASE_PERIOD, period);
    write_reg(lhsl_pkg::CFG_SYNC_LENGTH, pad(16'(sync_len), 8));
    write_reg(lhsl_pkg::CFG_DATA_BITS, pad(16'(n_bits), 4));
    write_reg(lhsl_pkg::CFG_STOP_ENABLE, pad(16'(stop_en), 1));
    write_reg(lhsl_pkg::CFG_STOP_LEVEL, pad(16'(stop_lvl), 1));
    cfg_we_i <= 1'b0;
  endtask

  // One configuration phase of random traffic; hold_at and pause_at place the
  // long receiver hold-off and the full sender pause (negative means none).
  task automatic run_setting(logic [9:0] thr, logic [15:0] period, logic [7:0] sync_len,
                             logic [3:0] n_bits, logic stop_en, logic stop_lvl,
                             int count, int pop_pct, int hold_at, int pause_at);
    program_link(thr, period, sync_len, n_bits, stop_en, stop_lvl);
    line_bits.delete();
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      if (i == pause_at) drain_results();
      send_item(make_request(pop_pct));
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fast timing and a one-bit preamble so the opening beats reach every link state.
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0001);
    program_link(10'd290, 16'd1, 8'd1, 4'd8, 1'b1, 1'b0);

    // Directed opening: refused requests, the no-op, threshold edges, all-ones fields.
    send_item(req(lhsl_pkg::FUNC_NOP, 10'h3FF, 8'hFF));
    send_item(req(lhsl_pkg::FUNC_POP, 10'h000, 8'h00));
    send_item(req(lhsl_pkg::FUNC_LOAD, 10'h000, 8'hFF));
    // Inverted reading equal to the threshold decodes as zero and adds jitter.
    send_item(req(lhsl_pkg::FUNC_TICK, 10'd733, 8'h00));
    repeat (6) send_item(req(lhsl_pkg::FUNC_TICK, 10'd732, 8'h00));
    repeat (4) send_item(req(lhsl_pkg::FUNC_TICK, 10'd1023, 8'h00));
    // Guard bits still counting: the load is refused.
    send_item(req(lhsl_pkg::FUNC_LOAD, 10'd0, 8'h00));
    repeat (4) send_item(req(lhsl_pkg::FUNC_TICK, 10'd0, 8'h00));
    send_item(req(lhsl_pkg::FUNC_LOAD, 10'd0, 8'hA5));
    send_item(req(lhsl_pkg::FUNC_LOAD, 10'd0, 8'h5A));
    send_item(req(lhsl_pkg::FUNC_POP, 10'd0, 8'h00));
    repeat (3) send_item(req(lhsl_pkg::FUNC_TICK, 10'd1023, 8'hFF));
    drain_results();

    // Long receiver hold-off and a full sender pause in the first random phase.
    run_setting(10'd290, 16'd1, 8'd3, 4'd8, 1'b1, 1'b0, 350, 30, 100, 220);
    // No pops: the ring fills and the next start bit drops the link.
    run_setting(10'd0, 16'd1, 8'd1, 4'd1, 1'b0, 1'b1, 450, 0, -1, -1);
    // Highest threshold: no reading decodes as one, so the link keeps searching.
    run_setting(10'd1023, 16'd2, 8'd2, 4'd4, 1'b1, 1'b1, 60, 20, -1, -1);
    // Longest period and preamble: only the wait countdown is exercised.
    run_setting(10'($urandom_range(1, 1022)), 16'hFFFF, 8'd255, 4'd8, 1'b0, 1'b0,
                40, 20, -1, -1);
    repeat (4)
      run_setting(10'($urandom_range(1, 1022)), 16'($urandom_range(1, 3)),
                  8'($urandom_range(1, 6)), 4'($urandom_range(1, 8)), 1'($urandom),
                  1'($urandom), 160, $urandom_range(5, 40), -1, -1);

    // Closing stretch at full rate on both sides.
    send_gaps_on = 1'b0;
    stall_gaps_on = 1'b0;
    run_setting(10'd512, 16'd1, 8'd2, 4'd7, 1'b1, 1'b1, 200, 25, -1, -1);

    repeat (5) @(posedge clk_i);
    if (board.errors == 0 && board.expected_status.size() == 0) begin
      $display("PASS led_half_duplex_serial_link_unit");
    end else begin
      $display("FAIL led_half_duplex_serial_link_unit");
    end
    $finish;
  end

endmodule
